>>> rtl/dnps_pkg.sv
// Shared types and constants for the dominance nearest-point search block.
package dnps_pkg;

   localparam int LANES       = 4;
   localparam int FIELD_W     = 32;
   localparam int DIST_W      = FIELD_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic       REQ_TARGET    = 1'b0;
   localparam logic       REQ_CANDIDATE = 1'b1;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_HIGH  = 2'd1;
   localparam logic [1:0] MODE_LOW   = 2'd2;

   localparam logic       REG_DIM_COUNT   = 1'b0;
   localparam logic       REG_SEARCH_MODE = 1'b1;

   localparam logic [15:0] NOT_FOUND_INDEX = 16'hFFFF;

   typedef struct packed {
      logic                      req_type;
      logic signed [FIELD_W-1:0] coord_0;
      logic signed [FIELD_W-1:0] coord_1;
      logic signed [FIELD_W-1:0] coord_2;
      logic signed [FIELD_W-1:0] coord_3;
      logic                      last_point;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] best_index;
      logic        found;
      logic        overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0] dim_count;
      logic [1:0] search_mode;
   } cfg_type;

   // Decoded transaction as it sits in the queue.
   typedef struct packed {
      logic                                is_cand;
      logic                                last;
      logic [LANES-1:0][FIELD_W-1:0]       coord;
      logic [LANES-1:0][DIST_W-1:0]        gap;
      logic [LANES-1:0]                    ge;
      logic [LANES-1:0]                    le;
   } op_type;

   typedef struct packed {
      logic pop;
      logic emit;
   } back_status_type;

endpackage

>>> rtl/dnps_front.sv
// Front end: accepts transactions, sign-extends, measures candidate distance to the target.
module dnps_front #(
   parameter int COORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dnps_pkg::req_payload_type req_payload,
   input  logic                     q_full,
   output logic                     push,
   output dnps_pkg::op_type         push_op
);

   localparam int COORD_W = (COORD_BITS < dnps_pkg::FIELD_W) ? COORD_BITS : dnps_pkg::FIELD_W;
   localparam int SHIFT   = dnps_pkg::FIELD_W - COORD_W;

   logic [dnps_pkg::LANES-1:0][dnps_pkg::FIELD_W-1:0] target_ff;
   logic [dnps_pkg::LANES-1:0][dnps_pkg::FIELD_W-1:0] target_in;
   logic [dnps_pkg::LANES-1:0][dnps_pkg::FIELD_W-1:0] raw;
   logic [dnps_pkg::LANES-1:0][dnps_pkg::FIELD_W-1:0] coord;
   logic signed [dnps_pkg::DIST_W-1:0]                diff;
   logic signed [dnps_pkg::FIELD_W-1:0]               shl;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   assign raw[0] = req_payload.coord_0;
   assign raw[1] = req_payload.coord_1;
   assign raw[2] = req_payload.coord_2;
   assign raw[3] = req_payload.coord_3;

   always_comb begin
      diff      = '0;
      shl       = '0;
      target_in = target_ff;
      push_op.is_cand = (req_payload.req_type == dnps_pkg::REQ_CANDIDATE);
      push_op.last    = req_payload.last_point;
      for (int i = 0; i < dnps_pkg::LANES; i++) begin
         shl      = signed'(raw[i] << SHIFT);
         coord[i] = shl >>> SHIFT;
         diff     = signed'({coord[i][dnps_pkg::FIELD_W-1], coord[i]})
                    - signed'({target_ff[i][dnps_pkg::FIELD_W-1], target_ff[i]});
         push_op.coord[i] = coord[i];
         push_op.gap[i]   = diff[dnps_pkg::DIST_W-1] ? -diff : diff;
         push_op.ge[i]    = signed'(coord[i]) >= signed'(target_ff[i]);
         push_op.le[i]    = signed'(coord[i]) <= signed'(target_ff[i]);
      end
      if (push && !push_op.is_cand) begin
         target_in = coord;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

endmodule

>>> rtl/dnps_queue.sv
// Two-entry queue between the front end and the search unit.
module dnps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dnps_pkg::op_type push_op,
   input  logic             pop,
   output logic             full,
   output logic             op_valid,
   output dnps_pkg::op_type op
);

   dnps_pkg::op_type               mem_ff [dnps_pkg::QUEUE_DEPTH];
   logic [dnps_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dnps_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dnps_pkg::QPTR_W:0]      count_ff, count_in;

   assign full     = (count_ff == (dnps_pkg::QPTR_W+1)'(dnps_pkg::QUEUE_DEPTH));
   assign op_valid = (count_ff != '0);
   assign op       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dnps_pkg::QPTR_W'(dnps_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dnps_pkg::QPTR_W'(dnps_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/dnps_back.sv
// Search unit: dominance test against the current best, set bookkeeping, result register.
module dnps_back #(
   parameter int MAX_DIMS   = 4,
   parameter int MAX_POINTS = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dnps_pkg::cfg_type            cfg,
   input  logic                         op_valid,
   input  dnps_pkg::op_type             op,
   output dnps_pkg::back_status_type    status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output dnps_pkg::rsp_payload_type    rsp_payload
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic [dnps_pkg::LANES-1:0][dnps_pkg::FIELD_W-1:0] target_ff, target_in;
   logic [dnps_pkg::LANES-1:0][dnps_pkg::FIELD_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]                 best_idx_ff, best_idx_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             found_ff, found_in;
   logic                             ovf_ff, ovf_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   dnps_pkg::rsp_payload_type        rsp_ff, rsp_in;

   logic                             produces, pop, plain, dom_ok, strict, side_ok;
   logic [dnps_pkg::LANES-1:0]       lane_en;
   logic signed [dnps_pkg::DIST_W-1:0] diff;
   logic [dnps_pkg::DIST_W-1:0]      db;
   logic [31:0]                      idx_wide;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign status.pop  = pop;
   assign status.emit = pop && produces;

   always_comb begin
      produces = op.is_cand && op.last;
      pop      = op_valid && (!produces || !rsp_valid_ff || !rsp_stall);
      plain    = (cfg.search_mode != dnps_pkg::MODE_HIGH) &&
                 (cfg.search_mode != dnps_pkg::MODE_LOW);

      dom_ok  = 1'b1;
      strict  = 1'b0;
      side_ok = 1'b1;
      diff    = '0;
      db      = '0;
      for (int i = 0; i < dnps_pkg::LANES; i++) begin
         lane_en[i] = (cfg.dim_count > 3'(i)) && (i < MAX_DIMS);
         diff = signed'({target_ff[i][dnps_pkg::FIELD_W-1], target_ff[i]})
                - signed'({best_ff[i][dnps_pkg::FIELD_W-1], best_ff[i]});
         db   = diff[dnps_pkg::DIST_W-1] ? -diff : diff;
         if (lane_en[i]) begin
            if (op.gap[i] > db) dom_ok = 1'b0;
            if (op.gap[i] < db) strict = 1'b1;
            if (cfg.search_mode == dnps_pkg::MODE_HIGH && !op.ge[i]) side_ok = 1'b0;
            if (cfg.search_mode == dnps_pkg::MODE_LOW && !op.le[i]) side_ok = 1'b0;
         end
      end

      target_in    = target_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      idx_wide     = '0;

      if (pop) begin
         if (!op.is_cand) begin
            target_in = op.coord;
         end else begin
            if (cnt_ff >= CNT_W'(MAX_POINTS)) begin
               ovf_in = 1'b1;
            end else begin
               if (cnt_ff == '0) begin
                  best_in     = op.coord;
                  best_idx_in = '0;
               end else if (dom_ok && strict && (plain || side_ok)) begin
                  best_in     = op.coord;
                  best_idx_in = cnt_ff;
                  found_in    = 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
            end
            if (op.last) begin
               idx_wide     = 32'(best_idx_in);
               rsp_valid_in = 1'b1;
               if (plain || found_in) begin
                  rsp_in.best_index = idx_wide[15:0];
                  rsp_in.found      = 1'b1;
               end else begin
                  rsp_in.best_index = dnps_pkg::NOT_FOUND_INDEX;
                  rsp_in.found      = 1'b0;
               end
               rsp_in.overflow = ovf_in;
               best_idx_in = '0;
               cnt_in      = '0;
               found_in    = 1'b0;
               ovf_in      = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         target_ff    <= '0;
         best_ff      <= '0;
         best_idx_ff  <= '0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         best_ff      <= best_in;
         best_idx_ff  <= best_idx_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/dominance_nearest_point_search.sv
// Top level of the dominance nearest-point search block.
// Takes one transaction per clock while req_stall is low: a target load or a
// candidate point. The front end sign-extends each candidate and measures its
// per-dimension distance to the target, a two-entry queue decouples it from the
// search unit, and the search unit compares that distance against the current best
// and updates it, one candidate per cycle unless a result waits behind a stalled
// rsp side. A set's result leaves through the queue and the output register;
// req_stall rises only when the queue is full, which happens only while a result
// waits behind a stalled rsp side. No clearing pass after reset.
module dominance_nearest_point_search #(
   parameter int MAX_DIMS   = 4,
   parameter int MAX_POINTS = 65536,
   parameter int COORD_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dnps_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dnps_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [2:0]                csr_wdata
);

   dnps_pkg::cfg_type         cfg_ff, cfg_in;
   dnps_pkg::op_type          push_op, q_op;
   dnps_pkg::back_status_type back_status;
   logic                      push, q_full, q_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dnps_pkg::REG_DIM_COUNT:   cfg_in.dim_count   = csr_wdata;
            dnps_pkg::REG_SEARCH_MODE: cfg_in.search_mode = csr_wdata[1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_count   <= 3'd4;
         cfg_ff.search_mode <= dnps_pkg::MODE_PLAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dnps_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_op     (push_op)
   );

   dnps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_op  (push_op),
      .pop      (back_status.pop),
      .full     (q_full),
      .op_valid (q_valid),
      .op       (q_op)
   );

   dnps_back #(
      .MAX_DIMS   (MAX_DIMS),
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .op_valid    (q_valid),
      .op          (q_op),
      .status      (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      back_status.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result issued over an undelivered result");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      back_status.emit |=> rsp_valid)
      else $error("issued result not presented");

   a_not_found_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.found) |-> (rsp_payload.best_index == dnps_pkg::NOT_FOUND_INDEX))
      else $error("not-found result carries an index");

endmodule
